// ===== rtl/ddhpd_pkg.sv =====
// ddhpd_pkg: shared types, constants and small functions of the heading PD unit.
// Used by the channel interfaces and by every module of the block.
// No dependencies.
package ddhpd_pkg;

    // CORDIC sizing
    localparam int CORDIC_STEPS    = 14;
    localparam int ATAN_TABLE_SIZE = 20;
    localparam int ITER_COUNT      = (CORDIC_STEPS < ATAN_TABLE_SIZE) ? CORDIC_STEPS
                                                                      : ATAN_TABLE_SIZE;
    localparam int ITER_W          = $clog2(ATAN_TABLE_SIZE);
    localparam int CW              = 36;   // x/y datapath: 17-bit vector << 16, plus growth
    localparam int ZW              = 20;   // angle accumulator, 2^-16 rad

    // angles, Q3.13
    localparam logic signed [16:0] ANG_PI17      = 17'sd25736;
    localparam logic signed [16:0] ANG_TWO_PI17  = 17'sd51472;
    localparam logic signed [17:0] ANG_PI18      = 18'sd25736;
    localparam logic signed [17:0] ANG_TWO_PI18  = 18'sd51472;
    localparam logic signed [15:0] REVERSE_LIMIT = 16'sd14155;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 2'd2;

    localparam logic [15:0] GAIN_P_RESET     = 16'd5120;
    localparam logic [15:0] GAIN_D_RESET     = 16'd640;
    localparam logic [6:0]  BASE_SPEED_RESET = 7'd30;

    // quadrant correction applied to the CORDIC angle
    typedef enum logic [1:0] {
        CORR_NONE,
        CORR_PLUS_PI,
        CORR_MINUS_PI
    } t_corr;

    typedef struct packed {
        logic signed [15:0] robot_x;
        logic signed [15:0] robot_y;
        logic signed [15:0] robot_heading;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [5:0]         speed_boost;
        logic [2:0]         robot_index;
        logic               team_select;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [2:0]         robot_index_out;
        logic               team_out;
        logic               driving_reversed;
    } t_out_item;

    // classified job handed from front to back
    typedef struct packed {
        logic signed [16:0] vec_x;     // difference vector, folded into the right half-plane
        logic signed [16:0] vec_y;
        logic               vec_zero;  // target on the robot: bearing is zero
        t_corr              corr;
        logic signed [15:0] heading;
        logic [5:0]         speed_boost;
        logic [2:0]         robot_index;
        logic               team_select;
    } t_job;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_d;
        logic [6:0]  base_speed;
    } t_cfg;

    // atan(2^-i) in 2^-16 rad, scaled as the vectoring loop expects
    function automatic logic [16:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ddhpd_in_if.sv =====
// ddhpd_in_if: valid/ready channel carrying one pose/target transaction.
// Depends on ddhpd_pkg.
interface ddhpd_in_if import ddhpd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ddhpd_out_if.sv =====
// ddhpd_out_if: valid/ready channel carrying one wheel-speed transaction.
// Depends on ddhpd_pkg.
interface ddhpd_out_if import ddhpd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/diff_drive_heading_pd_unit.sv =====
// diff_drive_heading_pd_unit: top level of the differential-drive heading PD unit.
// Depends on ddhpd_pkg, ddhpd_in_if, ddhpd_out_if, ddhpd_front, ddhpd_queue, ddhpd_back.
//
// Usage
//   i_in  (valid/ready): one transaction per robot update carrying pose, target,
//         speed boost and the pass-through robot index and team flag.
//   o_out (valid/ready): one transaction per input, in order: left/right wheel
//         speeds (Q8.8, saturated), robot index, team flag, reversed flag.
//   Config: i_cfg_we/i_cfg_idx/i_cfg_wdata write gain_p (0), gain_d (1) and
//         base_speed (2); indexes beyond that are ignored. Write only while idle.
// Timing
//   The back end works on one transaction at a time: it takes a job, runs
//   CORDIC_STEPS iterations (14 by default) of the shared vectoring CORDIC stage,
//   then steps through angle wrap, PD multiply, round, clamp and wheel split;
//   it takes no new job until the current result is written to the output register.
// Reset (i_rst_n, synchronous, active low) empties the front stage and queue,
//   clears the stored previous error and loads the default gains and speed.
// Back-pressure: a stalled output holds its transaction in the output register;
//   the back end finishes its next item and waits, while the front stage and the
//   two-entry queue keep accepting until they fill.
module diff_drive_heading_pd_unit import ddhpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ddhpd_in_if.sink              i_in,
    ddhpd_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg r_cfg;

    logic fq_valid;
    t_job fq_job;
    logic fq_ready;
    logic qb_valid;
    t_job qb_job;
    logic qb_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= GAIN_P_RESET;
            r_cfg.gain_d     <= GAIN_D_RESET;
            r_cfg.base_speed <= BASE_SPEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_P:     r_cfg.gain_p     <= i_cfg_wdata;
                CFG_GAIN_D:     r_cfg.gain_d     <= i_cfg_wdata;
                CFG_BASE_SPEED: r_cfg.base_speed <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // front: takes the transaction and folds the difference vector
    ddhpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (fq_valid),
        .o_job       (fq_job),
        .i_job_ready (fq_ready)
    );

    // decouples the front from the iterative back end
    ddhpd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .i_push_job   (fq_job),
        .o_push_ready (fq_ready),
        .o_pop_valid  (qb_valid),
        .o_pop_job    (qb_job),
        .i_pop_ready  (qb_ready)
    );

    // back: CORDIC bearing, error, PD law, wheel split, output register
    ddhpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qb_valid),
        .i_job       (qb_job),
        .o_job_ready (qb_ready),
        .i_cfg       (r_cfg),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/ddhpd_front.sv =====
// ddhpd_front: input stage; forms the difference vector and folds it into the
// right half-plane. Depends on ddhpd_pkg and ddhpd_in_if.
module ddhpd_front import ddhpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ddhpd_in_if.sink   i_in,
    output logic       o_job_valid,
    output t_job       o_job,
    input  logic       i_job_ready
);

    logic        r_valid;
    t_job        r_job;
    t_job        n_job;
    logic signed [16:0] dx;
    logic signed [16:0] dy;

    assign i_in.ready  = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        dx = $signed({i_in.data.target_x[15], i_in.data.target_x})
           - $signed({i_in.data.robot_x[15], i_in.data.robot_x});
        dy = $signed({i_in.data.target_y[15], i_in.data.target_y})
           - $signed({i_in.data.robot_y[15], i_in.data.robot_y});
        n_job.vec_zero    = (dx == '0) && (dy == '0);
        n_job.heading     = i_in.data.robot_heading;
        n_job.speed_boost = i_in.data.speed_boost;
        n_job.robot_index = i_in.data.robot_index;
        n_job.team_select = i_in.data.team_select;
        if (dx[16]) begin
            n_job.vec_x = -dx;
            n_job.vec_y = -dy;
            n_job.corr  = dy[16] ? CORR_MINUS_PI : CORR_PLUS_PI;
        end else begin
            n_job.vec_x = dx;
            n_job.vec_y = dy;
            n_job.corr  = CORR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
            r_job   <= n_job;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/ddhpd_queue.sv =====
// ddhpd_queue: two-entry job queue between front and back.
// Depends on ddhpd_pkg.
module ddhpd_queue import ddhpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_job,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_job,
    input  logic i_pop_ready
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/ddhpd_back.sv =====
// ddhpd_back: iterative CORDIC bearing, heading error, PD law, clamp and wheel split,
// with the output register. Depends on ddhpd_pkg and ddhpd_out_if.
module ddhpd_back import ddhpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_ready,
    input  t_cfg       i_cfg,
    ddhpd_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ITER,
        S_ANGLE,
        S_WRAP,
        S_ERR,
        S_MUL,
        S_SUM,
        S_CLAMP,
        S_OUT
    } t_state;

    localparam logic signed [ZW-1:0] Z_HALF = ZW'(4);

    t_state              r_state;
    logic [ITER_W-1:0]   r_iter;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    t_job                r_job;
    logic signed [17:0]  r_bear;
    logic [15:0]         r_hf;
    logic [15:0]         r_hr;
    logic [15:0]         r_bmod;
    logic signed [15:0]  r_err;
    logic                r_rev;
    logic signed [15:0]  r_prev;
    logic signed [33:0]  r_prod_p;
    logic signed [33:0]  r_prod_d;
    logic [15:0]         r_limit;
    logic signed [21:0]  r_drive;
    logic signed [17:0]  r_drive_c;
    logic                r_out_valid;
    t_out_item           r_out;

    // combinational datapath
    logic signed [CW-1:0] x_sh, y_sh;
    logic signed [ZW-1:0] ang;
    logic signed [ZW-1:0] z_sum, z_rnd;
    logic signed [17:0]   corr18, n_bear;
    logic signed [16:0]   hd17, hf17, hr17, hr_mod;
    logic [15:0]          n_bmod;
    logic signed [16:0]   df, dr, ef17, er17;
    logic signed [15:0]   ef, er;
    logic                 rev_now;
    logic signed [16:0]   err17, prev17, ediff;
    logic signed [16:0]   gp17, gd17;
    logic signed [33:0]   prod_p, prod_d;
    logic [7:0]           lim_units;
    logic signed [34:0]   acc;
    logic signed [21:0]   lim22;
    logic signed [17:0]   n_drive_c;
    logic signed [18:0]   d19, base19, left19, right19;
    logic                 drive_pos;
    logic                 out_free;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        // vectoring step
        x_sh = r_x >>> r_iter;
        y_sh = r_y >>> r_iter;
        ang  = $signed({{(ZW-17){1'b0}}, atan_entry(r_iter)});

        // round to Q3.13 and undo the half-plane fold
        z_sum = r_z + Z_HALF;
        z_rnd = z_sum >>> 3;
        case (r_job.corr)
            CORR_PLUS_PI:  corr18 = ANG_PI18;
            CORR_MINUS_PI: corr18 = -ANG_PI18;
            default:       corr18 = '0;
        endcase
        n_bear = r_job.vec_zero ? 18'sd0 : ($signed(z_rnd[17:0]) + corr18);

        // heading and reversed heading reduced into [0, 2pi)
        hd17 = $signed({r_job.heading[15], r_job.heading});
        hf17 = hd17[16] ? (hd17 + ANG_TWO_PI17) : hd17;
        hr17 = hd17 + ANG_PI17;
        if (hr17[16]) begin
            hr_mod = hr17 + ANG_TWO_PI17;
        end else if (hr17 >= ANG_TWO_PI17) begin
            hr_mod = hr17 - ANG_TWO_PI17;
        end else begin
            hr_mod = hr17;
        end

        // bearing reduced into [0, 2pi)
        if (r_bear[17]) begin
            n_bmod = 16'(r_bear + ANG_TWO_PI18);
        end else if (r_bear >= ANG_TWO_PI18) begin
            n_bmod = 16'(r_bear - ANG_TWO_PI18);
        end else begin
            n_bmod = r_bear[15:0];
        end

        // wrapped differences
        df = $signed({1'b0, r_hf}) - $signed({1'b0, r_bmod});
        dr = $signed({1'b0, r_hr}) - $signed({1'b0, r_bmod});
        if (df > ANG_PI17) begin
            ef17 = df - ANG_TWO_PI17;
        end else if (df < -ANG_PI17) begin
            ef17 = df + ANG_TWO_PI17;
        end else begin
            ef17 = df;
        end
        if (dr > ANG_PI17) begin
            er17 = dr - ANG_TWO_PI17;
        end else if (dr < -ANG_PI17) begin
            er17 = dr + ANG_TWO_PI17;
        end else begin
            er17 = dr;
        end
        ef      = ef17[15:0];
        er      = er17[15:0];
        rev_now = (ef > REVERSE_LIMIT) || (ef < -REVERSE_LIMIT);

        // PD products
        err17  = $signed({r_err[15], r_err});
        prev17 = $signed({r_prev[15], r_prev});
        ediff  = err17 - prev17;
        gp17   = $signed({1'b0, i_cfg.gain_p});
        gd17   = $signed({1'b0, i_cfg.gain_d});
        prod_p = gp17 * err17;
        prod_d = gd17 * ediff;
        lim_units = {1'b0, i_cfg.base_speed} + {2'b00, r_job.speed_boost};

        acc = $signed({r_prod_p[33], r_prod_p}) + $signed({r_prod_d[33], r_prod_d})
            + 35'sd4096;

        // clamp to +/- limit
        lim22 = $signed({6'b0, r_limit});
        if (r_drive > lim22) begin
            n_drive_c = lim22[17:0];
        end else if (r_drive < -lim22) begin
            n_drive_c = 18'(-lim22);
        end else begin
            n_drive_c = r_drive[17:0];
        end

        // wheel split
        d19       = $signed({r_drive_c[17], r_drive_c});
        base19    = $signed({3'b0, r_limit});
        drive_pos = !r_drive_c[17] && (r_drive_c != '0);
        if (!r_rev) begin
            if (drive_pos) begin
                left19  = base19;
                right19 = base19 - d19;
            end else begin
                left19  = base19 + d19;
                right19 = base19;
            end
        end else begin
            if (drive_pos) begin
                left19  = d19 - base19;
                right19 = -base19;
            end else begin
                left19  = -base19;
                right19 = -base19 - d19;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_x     <= $signed({{(CW-33){i_job.vec_x[16]}}, i_job.vec_x, 16'b0});
                        r_y     <= $signed({{(CW-33){i_job.vec_y[16]}}, i_job.vec_y, 16'b0});
                        r_z     <= '0;
                        r_iter  <= '0;
                        r_state <= S_ITER;
                    end
                end
                S_ITER: begin
                    if (!r_y[CW-1]) begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_z <= r_z + ang;
                    end else begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_z <= r_z - ang;
                    end
                    if (r_iter == ITER_W'(ITER_COUNT - 1)) begin
                        r_state <= S_ANGLE;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_ANGLE: begin
                    r_bear  <= n_bear;
                    r_hf    <= hf17[15:0];
                    r_hr    <= hr_mod[15:0];
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    r_bmod  <= n_bmod;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_rev   <= rev_now;
                    r_err   <= rev_now ? er : ef;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod_p <= prod_p;
                    r_prod_d <= prod_d;
                    r_limit  <= {lim_units, 8'b0};
                    r_prev   <= r_err;
                    r_state  <= S_SUM;
                end
                S_SUM: begin
                    r_drive <= acc[34:13];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_drive_c <= n_drive_c;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.left_speed       <= sat16(left19);
                        r_out.right_speed      <= sat16(right19);
                        r_out.robot_index_out  <= r_job.robot_index;
                        r_out.team_out         <= r_job.team_select;
                        r_out.driving_reversed <= r_rev;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
